// ===== hw/rtl/rgbq_pkg.sv =====
package rgbq_pkg;

  localparam int NCH    = 3;
  localparam int PIX_W  = 8;
  localparam int LVL_W  = 3;
  localparam int ERR_W  = 9;
  localparam int SUM_W  = 10;
  localparam int CFG_W  = 10;
  localparam int RST_WIDTH = 512;

  localparam int MAX_LVL = (1 << LVL_W) - 1;

  // per channel: red, green, blue
  localparam int DIV_TBL [NCH] = '{36, 36, 85};
  localparam int CAP_TBL [NCH] = '{7, 7, 3};
  localparam int LSB_TBL [NCH] = '{5, 2, 0};

  typedef logic [NCH-1:0][PIX_W-1:0] sample_t;

  typedef struct packed {
    sample_t            sample;
    logic [PIX_W-1:0]   packed_pixel;
  } pix_t;

endpackage

// ===== hw/rtl/rgbq_cell.sv =====
module rgbq_cell #(
  parameter int MAX_COLS = 512,
  parameter int CH       = 0,
  localparam int CW      = $clog2(MAX_COLS),
  localparam int CNT_W   = $clog2(MAX_COLS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          i_valid,
  output logic          i_ready,
  input  logic [CW-1:0] i_col,
  input  rgbq_pkg::pix_t i_word,
  output logic          o_valid,
  input  logic          o_ready,
  output logic [CW-1:0] o_col,
  output rgbq_pkg::pix_t o_word
);

  localparam int DIV   = rgbq_pkg::DIV_TBL[CH];
  localparam int CAP   = rgbq_pkg::CAP_TBL[CH];
  localparam int LSB   = rgbq_pkg::LSB_TBL[CH];
  localparam int PIX_W = rgbq_pkg::PIX_W;
  localparam int SUM_W = rgbq_pkg::SUM_W;
  localparam int ERR_W = rgbq_pkg::ERR_W;
  localparam int LVL_W = rgbq_pkg::LVL_W;

  logic                 vld_r;
  logic [CW-1:0]        col_r;
  rgbq_pkg::pix_t       word_r;
  logic [PIX_W-1:0]     above_q_r;
  logic                 hit_r;
  logic                 fwd_r;
  logic [PIX_W-1:0]     fwd_byte_r;
  logic [ERR_W-1:0]     err_r;
  logic [ERR_W-1:0]     err_nxt;
  logic [CNT_W-1:0]     hw_r;
  logic [PIX_W-1:0]     mem [MAX_COLS];

  logic                 load;
  logic                 fire;
  logic [PIX_W-1:0]     above;
  logic [SUM_W-1:0]     v;
  logic [SUM_W-1:0]     rem;
  logic [LVL_W-1:0]     lvl;

  assign fire    = vld_r && o_ready;
  assign i_ready = !vld_r || o_ready;
  assign load    = i_valid && i_ready;

  // entries past the fill mark were never written and read as zero
  always_comb begin
    if (fwd_r) begin
      above = fwd_byte_r;
    end else if (hit_r) begin
      above = above_q_r;
    end else begin
      above = '0;
    end
  end

  assign v = SUM_W'(word_r.sample[CH]) + SUM_W'(err_r[ERR_W-1:1])
           + SUM_W'(above[PIX_W-1:1]);

  // thermometer of level thresholds, capped
  always_comb begin
    lvl = '0;
    rem = v;
    for (int k = 1; k <= rgbq_pkg::MAX_LVL; k++) begin
      if (k <= CAP && v >= SUM_W'(k * DIV)) begin
        lvl = LVL_W'(k);
        rem = v - SUM_W'(k * DIV);
      end
    end
  end

  assign err_nxt = rem[ERR_W-1:0];

  assign o_valid = vld_r;
  assign o_col   = col_r;

  always_comb begin
    o_word              = word_r;
    o_word.packed_pixel = word_r.packed_pixel | (PIX_W'(lvl) << LSB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      err_r <= '0;
      hw_r  <= '0;
      fwd_r <= 1'b0;
    end else begin
      if (i_ready) begin
        vld_r <= i_valid;
      end
      if (fire) begin
        err_r <= err_nxt;
        if (CNT_W'(col_r) == hw_r) begin
          hw_r <= hw_r + CNT_W'(1);
        end
      end
      if (load) begin
        fwd_r <= fire && (col_r == i_col);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      col_r      <= i_col;
      word_r     <= i_word;
      above_q_r  <= mem[i_col];
      hit_r      <= CNT_W'(i_col) < hw_r;
      fwd_byte_r <= err_nxt[PIX_W-1:0];
    end
    if (fire) begin
      mem[col_r] <= err_nxt[PIX_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/rgb332_error_diffusion_quantizer.sv =====
// channel   direction  handshake                    payload
// in        input      in_valid / in_stall          in_red, in_green, in_blue
// out       output     out_valid / out_stall        out_packed_pixel
// cfg       input      cfg_valid / cfg_ready        cfg_line_width
//
// one pixel per clock sustained while out_stall is low; words pass through three
// channel cells and the output register. each cell closes its left error loop through err_r.
// reset is synchronous; the line stores are not swept, a fill mark per cell
// makes columns not yet written read as zero, so words are taken right away.
// out_stall backs up through the cells; in_stall rises only once every stage
// holds a word.
module rgb332_error_diffusion_quantizer #(
  parameter int MAX_COLS = 512
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_packed_pixel,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [9:0] cfg_line_width
);

  localparam int NCH   = rgbq_pkg::NCH;
  localparam int CFG_W = rgbq_pkg::CFG_W;
  localparam int PIX_W = rgbq_pkg::PIX_W;
  localparam int CW    = $clog2(MAX_COLS);
  localparam int CNT_W = $clog2(MAX_COLS + 1);
  localparam int WW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int RST_WIDTH = (rgbq_pkg::RST_WIDTH > MAX_COLS) ? MAX_COLS
                                                              : rgbq_pkg::RST_WIDTH;

  logic [WW-1:0]    width_r;
  logic [WW-1:0]    width_nxt;
  logic [CW-1:0]    column_r;
  logic [CW-1:0]    column_nxt;
  logic [CW-1:0]    col_cur;
  logic [WW-1:0]    col_inc;
  logic             out_valid_r;
  logic [PIX_W-1:0] out_packed_r;

  logic             vld [NCH+1];
  logic             rdy [NCH+1];
  logic [CW-1:0]    col [NCH+1];
  rgbq_pkg::pix_t   word [NCH+1];

  logic             in_accept;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_line_width == '0) begin
      width_nxt = WW'(1);
    end else if (WW'(cfg_line_width) > WW'(MAX_COLS)) begin
      width_nxt = WW'(MAX_COLS);
    end else begin
      width_nxt = WW'(cfg_line_width);
    end
  end

  // a width cut below the current column restarts at column zero
  assign col_cur    = (WW'(column_r) >= width_r) ? '0 : column_r;
  assign col_inc    = WW'(col_cur) + WW'(1);
  assign column_nxt = (col_inc >= width_r) ? '0 : col_inc[CW-1:0];

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = !rdy[0];

  assign vld[0]                = in_valid;
  assign col[0]                = col_cur;
  assign word[0].sample        = {in_blue, in_green, in_red};
  assign word[0].packed_pixel  = '0;

  for (genvar ch = 0; ch < NCH; ch++) begin : g_cell
    rgbq_cell #(
      .MAX_COLS (MAX_COLS),
      .CH       (ch)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .i_valid (vld[ch]),
      .i_ready (rdy[ch]),
      .i_col   (col[ch]),
      .i_word  (word[ch]),
      .o_valid (vld[ch+1]),
      .o_ready (rdy[ch+1]),
      .o_col   (col[ch+1]),
      .o_word  (word[ch+1])
    );
  end

  assign rdy[NCH]         = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_packed_pixel = out_packed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WW'(RST_WIDTH);
      column_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        width_r <= width_nxt;
      end
      if (in_accept) begin
        column_r <= column_nxt;
      end
      if (rdy[NCH]) begin
        out_valid_r <= vld[NCH];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vld[NCH] && rdy[NCH]) begin
      out_packed_r <= word[NCH].packed_pixel;
    end
  end

  // active width always clamped into the legal range
  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    width_r != '0 && width_r <= WW'(MAX_COLS))
    else $error("active line width out of range");

  // an empty chain never holds off the source
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!vld[1] && !vld[2] && !vld[3] && !out_valid_r) |-> !in_stall)
    else $error("input stalled while chain empty");

  // a finished word reaches an empty output register in the next cycle
  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (vld[NCH] && !out_valid_r) |=> out_valid)
    else $error("finished word not moved to output");

endmodule

// ===== sim/rgb332_pixel_check.sv =====
`timescale 1ns / 1ps

module rgb332_pixel_check (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_packed_pixel,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [9:0] cfg_line_width,
  output int         mismatches,
  output int         pending_pixels
);

  localparam int LINE_DEPTH = 512;
  localparam int DIVISOR [3] = '{36, 36, 85};
  localparam int TOP_LEVEL [3] = '{7, 7, 3};
  localparam int FIELD_LSB [3] = '{5, 2, 0};

  logic [9:0]  line_width;
  logic [8:0]  left_error [3];
  logic [7:0]  above_error [3][LINE_DEPTH];
  int unsigned column;
  logic [7:0]  expected_pixels [$];
  int          fail_count = 0;

  always @(posedge clk) begin : track
    logic [7:0]  want;
    logic [7:0]  chan [3];
    int unsigned row_width;
    int unsigned col;
    int unsigned sum;
    int unsigned level;
    int unsigned ch;
    int unsigned pos;
    if (!rst_n) begin
      line_width = 10'd512;
      column = 0;
      expected_pixels.delete();
      for (ch = 0; ch < 3; ch++) begin
        left_error[ch] = '0;
        for (pos = 0; pos < LINE_DEPTH; pos++) begin
          above_error[ch][pos] = '0;
        end
      end
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: packed pixel %02h arrived with none expected", $time,
                   out_packed_pixel);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_packed_pixel !== want) begin
            $display("%0t: packed pixel expected %02h, got %02h", $time, want,
                     out_packed_pixel);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        line_width = cfg_line_width;
      end
      if (in_valid && !in_stall) begin
        chan[0] = in_red;
        chan[1] = in_green;
        chan[2] = in_blue;
        // zero width counts as one, anything past the store as the store size
        row_width = (line_width == 0) ? 1 :
                    (line_width > LINE_DEPTH) ? LINE_DEPTH : line_width;
        // width shrunk mid row: restart at column zero
        col = (column >= row_width) ? 0 : column;
        want = '0;
        for (ch = 0; ch < 3; ch++) begin
          sum = chan[ch] + (left_error[ch] >> 1) + (above_error[ch][col] >> 1);
          level = sum / DIVISOR[ch];
          // capped level leaves the whole excess in the left error
          if (level > TOP_LEVEL[ch]) level = TOP_LEVEL[ch];
          left_error[ch] = 9'(sum - level * DIVISOR[ch]);
          above_error[ch][col] = left_error[ch][7:0];
          want = want | 8'(level << FIELD_LSB[ch]);
        end
        expected_pixels.push_back(want);
        column = (col + 1 >= row_width) ? 0 : col + 1;
      end
    end
    mismatches <= fail_count;
    pending_pixels <= expected_pixels.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int PHASES = 9;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_red = '0;
  logic [7:0] in_green = '0;
  logic [7:0] in_blue = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_packed_pixel;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [9:0] cfg_line_width = '0;
  int         mismatches;
  int         pending_pixels;
  bit         gaps_on = 1'b1;
  bit         hold_req = 1'b0;

  // extremes, values around the divisors, and a run of full scale to hit the caps
  logic [23:0] directed_pixels [24] = '{
    24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000000,
    24'h000000, 24'h232323, 24'h242424, 24'h474747, 24'h484848, 24'h545454,
    24'h555555, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hAA55AA, 24'h55AA55,
    24'h808080, 24'h7F7F7F, 24'h010101, 24'hFEFEFE, 24'hFFFFFF, 24'h000000
  };
  logic [9:0] phase_width [PHASES] = '{
    10'd1, 10'd0, 10'd1023, 10'd3, 10'd100, 10'd7, 10'd64, 10'd2, 10'd512
  };
  int phase_items [PHASES] = '{30, 20, 60, 50, 150, 40, 40, 30, 20};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rgb332_error_diffusion_quantizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_packed_pixel (out_packed_pixel),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_line_width   (cfg_line_width)
  );

  rgb332_pixel_check pixel_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_packed_pixel (out_packed_pixel),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_line_width   (cfg_line_width),
    .mismatches       (mismatches),
    .pending_pixels   (pending_pixels)
  );

  task automatic offer_pixel(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
    if (gaps_on && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic offer_random_pixels(input int count);
    logic [7:0] chan [3];
    int n;
    int ch;
    for (n = 0; n < count; n++) begin
      for (ch = 0; ch < 3; ch++) begin
        case ($urandom_range(9))
          0, 1:    chan[ch] = $urandom_range(1) ? 8'hFF : 8'h00;
          // land on or just past a level boundary of the red and green divider
          2:       chan[ch] = 8'($urandom_range(7) * 36 + $urandom_range(2));
          default: chan[ch] = 8'($urandom);
        endcase
      end
      offer_pixel(chan[0], chan[1], chan[2]);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pixels != 0);
  endtask

  task automatic write_width(input logic [9:0] w);
    cfg_valid <= 1'b1;
    cfg_line_width <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stalls, or a long hold-off on request
  initial begin
    int hold_count;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (hold_count = 0; hold_count < 64; hold_count++) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= rst_n && gaps_on && ($urandom_range(99) < 23);
      end
    end
  end

  initial begin
    int n;
    int p;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset width, clean line store
    for (n = 0; n < 24; n++) begin
      offer_pixel(directed_pixels[n][23:16], directed_pixels[n][15:8],
                  directed_pixels[n][7:0]);
    end
    drain_results();

    phase_width[6] = 10'($urandom_range(4, 511));
    for (p = 0; p < PHASES; p++) begin
      // rows are left part-done between phases, so widths change mid row
      write_width(phase_width[p]);
      gaps_on = (p != 3);
      if (p == 2 || p == 4) hold_req = 1'b1;
      offer_random_pixels(phase_items[p]);
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_pixels == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
